FILE: sv/integer_power_by_squaring_top_assert.svh
// Assertion macros for the integer power by squaring block.
`ifndef INTEGER_POWER_BY_SQUARING_TOP_ASSERT_SVH
`define INTEGER_POWER_BY_SQUARING_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define IPS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define IPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ips_pkg.sv
// Shared types and constants for the integer power by squaring block.
package ips_pkg;

  localparam int EXP_WIDTH   = 32;
  localparam int POWER_WIDTH = 64;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture a new transaction
    logic mul;    // register partial products
    logic upd;    // sum partial products, update base, result and exponent
    logic emit;   // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic e_zero; // no exponent bits left to process
  } status_t;

endpackage

FILE: sv/ips_in_if.sv
// Input channel: base and exponent with valid/ready handshake.
interface ips_in_if #(
  parameter int BASE_WIDTH = 32
);
  import ips_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [BASE_WIDTH-1:0]  base;
  logic signed [EXP_WIDTH-1:0]   exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

FILE: sv/ips_out_if.sv
// Output channel: power result with valid/ready handshake.
interface ips_out_if;
  import ips_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [POWER_WIDTH-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink   (input valid, input power, output ready);
endinterface

FILE: sv/integer_power_by_squaring_top.sv
// Top level of the integer power by squaring block.
// Usage:
//   req carries a signed base and a signed 32-bit exponent; rsp returns
//   power = base ** exponent, wrapped modulo 2**RESULT_WIDTH and
//   sign-extended to 64 bits. A zero or negative exponent returns 1.
//   Both channels use valid/ready; a transaction moves when both are high.
// Operation:
//   Each exponent bit passes through S_MUL, which registers the split
//   partial products of the two multiply units, and then S_ADD, which sums
//   them and updates the base, result and exponent. The scan stops once no
//   set bits remain. One transaction is processed at a time.
// Reset and stalls:
//   rst (synchronous) returns the controller to idle and drops rsp.valid.
//   The result waits in an output register; a new request is accepted
//   while it is stalled, but the next result waits for that slot to free.
module integer_power_by_squaring_top #(
  parameter int BASE_WIDTH   = 32,
  parameter int RESULT_WIDTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  ips_in_if.sink        req,
  ips_out_if.source     rsp
);
  import ips_pkg::*;

  `include "integer_power_by_squaring_top_assert.svh"

  cmd_t    cmd;
  status_t status;

  ips_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ips_dp #(
    .BASE_WIDTH   (BASE_WIDTH),
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .status   (status),
    .base     (req.base),
    .exponent (req.exponent),
    .power    (rsp.power)
  );

  // Checks
  `IPS_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready, "request accepted while busy")
  `IPS_ASSERT_SAME(a_upd_after_mul, clk, rst, cmd.upd, $past(cmd.mul), "update without partial products")
  `IPS_ASSERT_SAME(a_emit_slot_free, clk, rst, cmd.emit, !rsp.valid || rsp.ready, "result overwrites pending output")
  `IPS_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, rsp.valid, "emitted result not presented")

endmodule

FILE: sv/ips_ctrl.sv
// Controller state machine for the integer power by squaring block.
module ips_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ips_pkg::status_t status,
  output ips_pkg::cmd_t    cmd
);
  import ips_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

  state_t state;

  // Commands decoded from state
  assign in_ready = (state == S_IDLE);
  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.mul  = (state == S_MUL) && !status.e_zero;
  assign cmd.upd  = (state == S_ADD);
  assign cmd.emit = (state == S_OUT) && (!out_valid || out_ready);

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_MUL;
        end
        S_MUL: begin
          if (status.e_zero) state <= S_OUT;
          else               state <= S_ADD;
        end
        S_ADD: begin
          state <= S_MUL;
        end
        S_OUT: begin
          if (cmd.emit) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/ips_dp.sv
// Datapath: square and multiply units built from split partial products.
module ips_dp #(
  parameter int BASE_WIDTH   = 32,
  parameter int RESULT_WIDTH = 64
) (
  input  logic                                   clk,
  input  ips_pkg::cmd_t                          cmd,
  output ips_pkg::status_t                       status,
  input  logic signed [BASE_WIDTH-1:0]           base,
  input  logic signed [ips_pkg::EXP_WIDTH-1:0]   exponent,
  output logic signed [ips_pkg::POWER_WIDTH-1:0] power
);
  import ips_pkg::*;

  // Operands split into a low half and a high part
  localparam int HALF = (RESULT_WIDTH + 1) / 2;
  localparam int HI_W = RESULT_WIDTH - HALF;

  logic [RESULT_WIDTH-1:0] acc;
  logic [RESULT_WIDTH-1:0] b_reg;
  logic [EXP_WIDTH-2:0]    e_reg;

  // Unit 0 squares the base, unit 1 multiplies the result by the base
  logic [RESULT_WIDTH-1:0] op_a [2];
  logic [2*HALF-1:0]       pp_ll [2];
  logic [HI_W-1:0]         pp_lh [2];
  logic [HI_W-1:0]         pp_hl [2];
  logic [HI_W-1:0]         pp_mid [2];
  logic [RESULT_WIDTH-1:0] prod  [2];

  assign op_a[0] = b_reg;
  assign op_a[1] = acc;

  assign status.e_zero = (e_reg == '0);

  // Product sum, wrapped to the result width
  always_comb begin
    for (int u = 0; u < 2; u++) begin
      pp_mid[u] = pp_lh[u] + pp_hl[u];
      prod[u]   = RESULT_WIDTH'(pp_ll[u]) + {pp_mid[u], {HALF{1'b0}}};
    end
  end

  // Partial product registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      for (int u = 0; u < 2; u++) begin
        pp_ll[u] <= (2*HALF)'(op_a[u][HALF-1:0]) * (2*HALF)'(b_reg[HALF-1:0]);
        pp_lh[u] <= HI_W'(op_a[u][HALF-1:0]) * b_reg[RESULT_WIDTH-1:HALF];
        pp_hl[u] <= op_a[u][RESULT_WIDTH-1:HALF] * HI_W'(b_reg[HALF-1:0]);
      end
    end
  end

  // Working registers and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc   <= RESULT_WIDTH'(1);
      b_reg <= RESULT_WIDTH'(POWER_WIDTH'(base));
      // Negative exponent behaves as zero
      e_reg <= exponent[EXP_WIDTH-1] ? '0 : exponent[EXP_WIDTH-2:0];
    end else if (cmd.upd) begin
      b_reg <= prod[0];
      if (e_reg[0]) acc <= prod[1];
      e_reg <= e_reg >> 1;
    end
    if (cmd.emit) begin
      power <= POWER_WIDTH'(signed'(acc));
    end
  end

endmodule
